FILE: src/ntc_thermistor_temperature_top_assert.svh
// Assertion macros used by the top file to check this block.
`ifndef NTC_THERMISTOR_TEMPERATURE_TOP_ASSERT_SVH
`define NTC_THERMISTOR_TEMPERATURE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ntc_thermistor_temperature: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ntc_thermistor_temperature: assertion failed");

`endif

FILE: src/ntc_pkg.sv
package ntc_pkg;

	localparam int ADC_BITS = 12;
	localparam int ADC_MAX = (1 << ADC_BITS) - 1;
	localparam int LOG_TABLE_BITS_DEF = 8;
	localparam int LOG_FRAC = 28;
	localparam int LN2_Q24 = 11629080;
	localparam int T_MAX = 69928;
	localparam int T_MIN = -69928;
	localparam int KELVIN_OFS = 69926;
	localparam int Q_LIMIT = T_MAX + KELVIN_OFS;
	// Smallest rounded T_K*2560 plus one whose tenth runs past Q_LIMIT.
	localparam int Q10_LIMIT = (Q_LIMIT + 1) * 10;
	// Reciprocals for exact division by constants: by 100 on 15-bit values and
	// by 10 on 21-bit values.
	localparam int DIV100_RECIP = 41944;
	localparam int DIV10_RECIP = 3355444;
	// Eight-bit digits in the 48-bit dividend of the divide by 100.
	localparam int T0_DIGITS = 6;
	localparam int QDEPTH = 2;
	localparam int QPTR_BITS = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		CFG_AVG_COUNT  = 3'd0,
		CFG_OPEN_THR   = 3'd1,
		CFG_BETA_CABLE = 3'd2,
		CFG_BETA_SMD   = 3'd3,
		CFG_BETA_FIX   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  avg_count;
		logic [11:0] open_threshold;
		logic [12:0] beta_cable;
		logic [12:0] beta_smd;
		logic [12:0] beta_fix;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  ch;
		logic [19:0] sum;
		logic [8:0]  cnt;
		logic        open;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_PREP1,
		B_PREP2,
		B_NORM,
		B_LOGMUL,
		B_LOGADD,
		B_DIFF,
		B_MULH,
		B_MULL,
		B_T0MUL,
		B_T0DIV,
		B_DEN,
		B_DIVQ,
		B_Q10WAIT,
		B_SAT,
		B_DONE
	} back_state_t;

	// log2(1 + i/2^lbits) in Q28 by repeated squaring; evaluated at elaboration.
	function automatic logic [28:0] log_rom_entry(input int i, input int lbits);
		logic [63:0] y;
		logic [28:0] r;
		y = (64'd1 << 30) + (64'(i) << (30 - lbits));
		r = '0;
		if (i >= (1 << lbits)) begin
			r = 29'(1) << LOG_FRAC;
		end else begin
			for (int k = 0; k < LOG_FRAC; k++) begin
				y = (y * y) >> 30;
				r = {r[27:0], 1'b0};
				if (y >= (64'd2 << 30)) begin
					y = y >> 1;
					r[0] = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: src/ntc_front.sv
module ntc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [2:0]        probe_channel,
	input  logic [11:0]       adc_sample,
	input  ntc_pkg::cfg_t     cfg,
	output logic              job_push,
	output ntc_pkg::job_t     job
);

	logic [19:0] sum_q;
	logic [7:0]  cnt_q;
	logic [2:0]  gch_q;

	logic        restart;
	logic [19:0] new_sum;
	logic [7:0]  new_cnt;
	logic [7:0]  n_req;
	logic        complete;
	logic [8:0]  cnt_full;
	logic [20:0] thr_total;

	always_comb begin
		restart = (cnt_q == 8'd0) || (probe_channel != gch_q);
		new_sum = (restart ? 20'd0 : sum_q) + 20'(adc_sample);
		new_cnt = (restart ? 8'd0 : cnt_q) + 8'd1;
		n_req = (cfg.avg_count == 8'd0) ? 8'd1 : cfg.avg_count;
		complete = (new_cnt == 8'd0) || (new_cnt >= n_req);
		cnt_full = (new_cnt == 8'd0) ? 9'd256 : {1'b0, new_cnt};
		thr_total = 21'(cfg.open_threshold) * 21'(cnt_full);
		job.ch = probe_channel;
		job.sum = new_sum;
		job.cnt = cnt_full;
		job.open = {1'b0, new_sum} < thr_total;
		job_push = take && complete;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			gch_q <= '0;
		end else if (take) begin
			gch_q <= probe_channel;
			if (complete) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= new_sum;
				cnt_q <= new_cnt;
			end
		end
	end

endmodule

FILE: src/ntc_fifo.sv
module ntc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  ntc_pkg::job_t wdata,
	input  logic          rd,
	output ntc_pkg::job_t rdata,
	output logic          q_full,
	output logic          q_empty
);

	ntc_pkg::job_t mem [ntc_pkg::QDEPTH];
	logic [ntc_pkg::QPTR_BITS-1:0] wp_q, rp_q;
	logic [ntc_pkg::QPTR_BITS:0]   count_q;

	assign q_full  = (count_q == (ntc_pkg::QPTR_BITS+1)'(ntc_pkg::QDEPTH));
	assign q_empty = (count_q == '0);
	assign rdata   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !q_full) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (wr && !q_full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd && !q_empty) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + ((wr && !q_full) ? 1'b1 : 1'b0)
				- ((rd && !q_empty) ? 1'b1 : 1'b0);
		end
	end

endmodule

FILE: src/ntc_div.sv
module ntc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [39:0] divisor,
	output logic        done,
	output logic [63:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] n_q;
	logic [39:0] rem_q;
	logic [39:0] dvsr_q;

	logic [40:0] trial;
	logic        ge;

	assign done = done_q;
	assign quot = n_q;

	always_comb begin
		trial = {rem_q, n_q[63]};
		ge = trial >= {1'b0, dvsr_q};
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q <= dividend;
			rem_q <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 40'(trial - {1'b0, dvsr_q}) : trial[39:0];
			n_q <= {n_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: src/ntc_back.sv
module ntc_back #(
	parameter int LOG_TABLE_BITS = ntc_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ntc_pkg::cfg_t      cfg,
	input  ntc_pkg::job_t      job,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [17:0] temp_out,
	output logic [2:0]         out_channel,
	output logic               open_circuit,
	output logic               range_fault
);

	localparam int SH = 32 - LOG_TABLE_BITS;
	localparam int NROM = (1 << LOG_TABLE_BITS) + 1;

	logic [28:0] rom [NROM];
	for (genvar g = 0; g < NROM; g++) begin : g_rom
		assign rom[g] = ntc_pkg::log_rom_entry(g, LOG_TABLE_BITS);
	end

	ntc_pkg::back_state_t st_q, st_d;
	ntc_pkg::job_t job_q;
	logic [20:0] d1_q;
	logic [27:0] d2_q;
	logic [47:0] x_q;
	logic [5:0]  shf_q;
	logic        which_q;
	logic [28:0] a_q;
	logic [28+SH:0] prod_q;
	logic [5:0]  p_q;
	logic [34:0] lognum_q, logden_q;
	logic        neg_q;
	logic [33:0] dmag_q;
	logic [58:0] acc_q;
	logic [25:0] mag20_q;
	logic [47:0] t0x_q;
	logic [6:0]  rem100_q;
	logic [2:0]  dcnt_q;
	logic [35:0] t0ln_q;
	logic [36:0] denom_q;
	logic [63:0] q_q;
	logic signed [17:0] temp_q;
	logic        fault_q, open_q;
	logic        res_valid_q;

	logic [20:0] mc;
	logic [21:0] twomc;
	logic [12:0] beta;
	logic [31:0] f;
	logic [LOG_TABLE_BITS-1:0] idx;
	logic [LOG_TABLE_BITS:0]   idx_p1;
	logic [SH-1:0] rem;
	logic [28:0] rom_a, rom_b;
	logic [34:0] lg;
	logic [58:0] mul_sum;
	logic [32:0] b20;
	logic [36:0] denom;
	logic [39:0] dvsr10;
	logic [14:0] v100;
	logic [30:0] prod100;
	logic [7:0]  qd100;
	logic [6:0]  rem100;
	logic [42:0] q_prod;
	logic        slot_free;

	logic        div_start;
	logic [63:0] div_dividend;
	logic [39:0] div_divisor;
	logic        div_done;
	logic [63:0] div_quot;

	ntc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign empty = !res_valid_q;
	assign slot_free = !res_valid_q || pop;

	always_comb begin
		mc = 21'(job_q.cnt) * 21'(ntc_pkg::ADC_MAX);
		twomc = {mc, 1'b0};
		unique case (job_q.ch)
			3'd6: beta = cfg.beta_smd;
			3'd7: beta = cfg.beta_fix;
			default: beta = cfg.beta_cable;
		endcase
		f = x_q[46:15];
		idx = f[31:SH];
		idx_p1 = {1'b0, idx} + 1'b1;
		rem = f[SH-1:0];
		rom_a = rom[{1'b0, idx}];
		rom_b = rom[idx_p1];
		lg = 35'({p_q, 28'b0}) + 35'(a_q) + 35'(prod_q >> SH);
		mul_sum = acc_q + 59'(dmag_q[16:0]) * 59'(ntc_pkg::LN2_Q24) + (59'(1) << 31);
		b20 = {beta, 20'b0};
		denom = neg_q ? 37'(b20) - 37'(t0ln_q) : 37'(b20) + 37'(t0ln_q);
		dvsr10 = 40'(denom_q) * 40'd10;
		// One base-256 digit step of the long division by 100.
		v100 = {rem100_q, t0x_q[47:40]};
		prod100 = 31'(v100) * 31'(ntc_pkg::DIV100_RECIP);
		qd100 = prod100[29:22];
		rem100 = 7'(v100 - 15'(qd100) * 15'd100);
		q_prod = 43'(q_q[20:0]) * 43'(ntc_pkg::DIV10_RECIP);
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		div_start = 1'b0;
		div_dividend = '0;
		div_divisor = '0;
		unique case (st_q)
			ntc_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					st_d = job.open ? ntc_pkg::B_DONE : ntc_pkg::B_PREP1;
				end
			end
			ntc_pkg::B_PREP1: begin
				st_d = (twomc <= {2'b0, job_q.sum}) ? ntc_pkg::B_DONE : ntc_pkg::B_PREP2;
			end
			ntc_pkg::B_PREP2: st_d = ntc_pkg::B_NORM;
			ntc_pkg::B_NORM: begin
				if (x_q[47]) begin
					st_d = ntc_pkg::B_LOGMUL;
				end
			end
			ntc_pkg::B_LOGMUL: st_d = ntc_pkg::B_LOGADD;
			ntc_pkg::B_LOGADD: st_d = which_q ? ntc_pkg::B_DIFF : ntc_pkg::B_NORM;
			ntc_pkg::B_DIFF: st_d = ntc_pkg::B_MULH;
			ntc_pkg::B_MULH: st_d = ntc_pkg::B_MULL;
			ntc_pkg::B_MULL: st_d = ntc_pkg::B_T0MUL;
			ntc_pkg::B_T0MUL: st_d = ntc_pkg::B_T0DIV;
			ntc_pkg::B_T0DIV: begin
				if (dcnt_q == 3'(ntc_pkg::T0_DIGITS - 1)) begin
					st_d = ntc_pkg::B_DEN;
				end
			end
			ntc_pkg::B_DEN: begin
				st_d = (neg_q && {3'b0, b20} <= {1'b0, t0ln_q}) ? ntc_pkg::B_DONE
					: ntc_pkg::B_DIVQ;
			end
			ntc_pkg::B_DIVQ: begin
				if (denom_q == '0) begin
					st_d = ntc_pkg::B_DONE;
				end else begin
					div_start = 1'b1;
					div_divisor = dvsr10;
					div_dividend = {8'b0, 28'(beta * 28'd29815), 28'b0}
						+ 64'(dvsr10 >> 1);
					st_d = ntc_pkg::B_Q10WAIT;
				end
			end
			ntc_pkg::B_Q10WAIT: begin
				if (div_done) begin
					st_d = ntc_pkg::B_SAT;
				end
			end
			ntc_pkg::B_SAT: st_d = ntc_pkg::B_DONE;
			ntc_pkg::B_DONE: begin
				if (slot_free) begin
					st_d = ntc_pkg::B_IDLE;
				end
			end
			default: st_d = ntc_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ntc_pkg::B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ntc_pkg::B_DONE && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ntc_pkg::B_IDLE: begin
				job_q <= job;
				open_q <= job.open;
				fault_q <= 1'b0;
				temp_q <= 18'(ntc_pkg::T_MIN);
			end
			ntc_pkg::B_PREP1: begin
				if (twomc <= {2'b0, job_q.sum}) begin
					fault_q <= 1'b1;
					temp_q <= 18'(ntc_pkg::T_MAX);
				end
				d1_q <= 21'(twomc - {2'b0, job_q.sum});
				d2_q <= 28'(28'(job_q.sum) * 28'd153 + 28'(mc) * 28'd30);
			end
			ntc_pkg::B_PREP2: begin
				x_q <= 48'(d1_q) * 48'd795600;
				shf_q <= '0;
				which_q <= 1'b0;
			end
			ntc_pkg::B_NORM: begin
				// Coarse steps of eight bits, then single bits, to the leading one.
				if (x_q[47:40] == 8'd0) begin
					x_q <= {x_q[39:0], 8'b0};
					shf_q <= shf_q + 6'd8;
				end else if (!x_q[47]) begin
					x_q <= {x_q[46:0], 1'b0};
					shf_q <= shf_q + 6'd1;
				end
			end
			ntc_pkg::B_LOGMUL: begin
				a_q <= rom_a;
				prod_q <= (29+SH)'(rom_b - rom_a) * (29+SH)'(rem);
				p_q <= 6'd47 - shf_q;
			end
			ntc_pkg::B_LOGADD: begin
				if (which_q) begin
					logden_q <= lg;
				end else begin
					lognum_q <= lg;
					x_q <= 48'(d2_q) * 48'd10000;
					shf_q <= '0;
					which_q <= 1'b1;
				end
			end
			ntc_pkg::B_DIFF: begin
				neg_q <= lognum_q < logden_q;
				dmag_q <= (lognum_q < logden_q) ? 34'(logden_q - lognum_q)
					: 34'(lognum_q - logden_q);
			end
			ntc_pkg::B_MULH: begin
				acc_q <= (59'(dmag_q[33:17]) * 59'(ntc_pkg::LN2_Q24)) << 17;
			end
			ntc_pkg::B_MULL: mag20_q <= mul_sum[57:32];
			ntc_pkg::B_T0MUL: begin
				t0x_q <= 48'(mag20_q) * 48'd29815 + 48'd50;
				rem100_q <= '0;
				dcnt_q <= '0;
			end
			ntc_pkg::B_T0DIV: begin
				// Quotient digits shift in from the bottom as the dividend leaves the top.
				t0x_q <= {t0x_q[39:0], qd100};
				rem100_q <= rem100;
				dcnt_q <= dcnt_q + 3'd1;
				t0ln_q <= {t0x_q[27:0], qd100};
			end
			ntc_pkg::B_DEN: begin
				denom_q <= denom;
				if (neg_q && {3'b0, b20} <= {1'b0, t0ln_q}) begin
					fault_q <= 1'b1;
					temp_q <= 18'(ntc_pkg::T_MAX);
				end
			end
			ntc_pkg::B_DIVQ: begin
				if (denom_q == '0) begin
					fault_q <= 1'b1;
					temp_q <= 18'(ntc_pkg::T_MAX);
				end
			end
			ntc_pkg::B_Q10WAIT: begin
				if (div_done) begin
					q_q <= div_quot + 64'd1;
				end
			end
			ntc_pkg::B_SAT: begin
				// The result can only run past the upper limit.
				if (q_q >= 64'(ntc_pkg::Q10_LIMIT)) begin
					fault_q <= 1'b1;
					temp_q <= 18'(ntc_pkg::T_MAX);
				end else begin
					temp_q <= q_prod[42:25] - 18'(ntc_pkg::KELVIN_OFS);
				end
			end
			ntc_pkg::B_DONE: begin
				if (slot_free) begin
					temp_out <= temp_q;
					out_channel <= job_q.ch;
					open_circuit <= open_q;
					range_fault <= fault_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/ntc_thermistor_temperature_top.sv
// NTC thermistor temperature converter. Samples are accepted one per cycle while
// the two-entry group queue has room; every avg_count samples of one channel make
// a group, and a channel change restarts the group. Each group then passes through
// the conversion engine: the two log2 evaluations (leading-one search plus table
// interpolation), the digit-wise divide of T0*ln by 100, and the bit-serial divide
// of the beta equation. An open probe skips the conversion. Results wait in an
// output register until popped. Config writes are always taken (cfg_ready is
// always high) and belong to idle periods.
`include "ntc_thermistor_temperature_top_assert.svh"

module ntc_thermistor_temperature_top #(
	parameter int LOG_TABLE_BITS = ntc_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         probe_channel,
	input  logic [11:0]        adc_sample,
	output logic               empty,
	input  logic               pop,
	output logic signed [17:0] temp_out,
	output logic [2:0]         out_channel,
	output logic               open_circuit,
	output logic               range_fault,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data
);

	ntc_pkg::cfg_t cfg_q;
	ntc_pkg::job_t front_job, q_job;
	logic job_push, q_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;
	assign full = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.avg_count <= 8'd1;
			cfg_q.open_threshold <= 12'd27;
			cfg_q.beta_cable <= 13'd3977;
			cfg_q.beta_smd <= 13'd3435;
			cfg_q.beta_fix <= 13'd3977;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ntc_pkg::CFG_AVG_COUNT:  cfg_q.avg_count <= cfg_data[7:0];
				ntc_pkg::CFG_OPEN_THR:   cfg_q.open_threshold <= cfg_data[11:0];
				ntc_pkg::CFG_BETA_CABLE: cfg_q.beta_cable <= cfg_data;
				ntc_pkg::CFG_BETA_SMD:   cfg_q.beta_smd <= cfg_data;
				ntc_pkg::CFG_BETA_FIX:   cfg_q.beta_fix <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ntc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (push && !full),
		.probe_channel (probe_channel),
		.adc_sample    (adc_sample),
		.cfg           (cfg_q),
		.job_push      (job_push),
		.job           (front_job)
	);

	ntc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_push),
		.wdata   (front_job),
		.rd      (q_pop),
		.rdata   (q_job),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	ntc_back #(
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.job          (q_job),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.temp_out     (temp_out),
		.out_channel  (out_channel),
		.open_circuit (open_circuit),
		.range_fault  (range_fault)
	);

	`NTC_ASSERT_NOW(a_open_result, !empty && open_circuit,
		!range_fault && temp_out == 18'(ntc_pkg::T_MIN))
	`NTC_ASSERT_NOW(a_fault_clamped, !empty && range_fault,
		temp_out == 18'(ntc_pkg::T_MAX) || temp_out == 18'(ntc_pkg::T_MIN))
	`NTC_ASSERT_NOW(a_temp_range, !empty,
		temp_out <= 18'sd69928 && temp_out >= -18'sd69928)
	`NTC_ASSERT_NEXT(a_avg_write, cfg_valid && cfg_index == ntc_pkg::CFG_AVG_COUNT,
		cfg_q.avg_count == $past(cfg_data[7:0]))

endmodule

FILE: tb/ntc_thermistor_temperature_top_tb.sv
`timescale 1ns / 100ps

module ntc_thermistor_temperature_top_tb;

	typedef struct {
		logic [2:0]  ch;
		logic [11:0] smp;
	} sample_t;

	typedef struct {
		logic signed [17:0] temp;
		logic [2:0]         ch;
		logic               open;
		logic               fault;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [2:0]         probe_channel = '0;
	logic [11:0]        adc_sample = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [17:0] temp_out;
	logic [2:0]         out_channel;
	logic               open_circuit;
	logic               range_fault;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [12:0]        cfg_data = '0;

	ntc_thermistor_temperature_top uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model of the block's configuration and group accumulator.
	logic [7:0]  m_avg = 8'd1;
	logic [11:0] m_thr = 12'd27;
	logic [12:0] m_beta_cable = 13'd3977;
	logic [12:0] m_beta_smd = 13'd3435;
	logic [12:0] m_beta_fix = 13'd3977;
	logic [19:0] grp_sum = '0;
	logic [7:0]  grp_cnt = '0;
	logic [2:0]  grp_ch = '0;

	longint unsigned log2_tab[0:256];
	sample_t  samples_to_send[$];
	reading_t readings_due[$];
	int errors = 0;
	int n_samples = 0, n_readings = 0, n_open = 0, n_fault = 0;
	int send_gap = 0, recv_gap = 0, hold_left = 0;
	bit long_hold_req = 0, long_hold_done = 0, no_idle = 0;

	function automatic void fill_log2_tab();
		longint unsigned y;
		longint unsigned r;
		for (int i = 0; i < 256; i++) begin
			y = (64'd1 << 30) + (64'(i) << 22);
			r = 0;
			for (int k = 0; k < 28; k++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= (64'd2 << 30)) begin
					y = y >> 1;
					r = r | 1;
				end
			end
			log2_tab[i] = r;
		end
		log2_tab[256] = 64'd1 << 28;
	endfunction

	function automatic longint unsigned log2_q28(longint unsigned v);
		int p;
		longint unsigned f, idx, rem, a, b;
		p = 63;
		while (p > 0 && v[p] == 1'b0)
			p--;
		if (p >= 32)
			f = (v >> (p - 32)) & 64'hFFFF_FFFF;
		else
			f = (v << (32 - p)) & 64'hFFFF_FFFF;
		idx = f >> 24;
		rem = f & 64'hFF_FFFF;
		a = log2_tab[idx];
		b = log2_tab[idx + 1];
		return (64'(p) << 28) + a + (((b - a) * rem) >> 24);
	endfunction

	// Beta equation on a completed group, result in 1/256 degC.
	function automatic int beta_temp(logic [2:0] ch, longint unsigned s, longint unsigned c,
			output logic fault);
		longint unsigned mc, beta, num, den, ln_n, ln_d, dmag, mag20, t0ln, b20, denom;
		longint unsigned numer, d, q10;
		longint t;
		bit neg;
		fault = 1'b0;
		mc = 64'(ntc_pkg::ADC_MAX) * c;
		beta = (ch == 3'd6) ? m_beta_smd : (ch == 3'd7) ? m_beta_fix : m_beta_cable;
		if (2 * mc <= s) begin
			fault = 1'b1;
			return ntc_pkg::T_MAX;
		end
		num = 64'd5200 * 153 * (2 * mc - s);
		den = 64'd10000 * (153 * s + 30 * mc);
		ln_n = log2_q28(num);
		ln_d = log2_q28(den);
		neg = ln_n < ln_d;
		dmag = neg ? ln_d - ln_n : ln_n - ln_d;
		mag20 = (dmag * 64'd11629080 + (64'd1 << 31)) >> 32;
		t0ln = (mag20 * 29815 + 50) / 100;
		b20 = beta << 20;
		if (neg) begin
			if (t0ln >= b20) begin
				fault = 1'b1;
				return ntc_pkg::T_MAX;
			end
			denom = b20 - t0ln;
		end else begin
			denom = b20 + t0ln;
		end
		if (denom == 0) begin
			fault = 1'b1;
			return ntc_pkg::T_MAX;
		end
		numer = (beta * 29815) << 28;
		d = 10 * denom;
		q10 = (numer + d / 2) / d;
		t = longint'((q10 + 1) / 10) - ntc_pkg::KELVIN_OFS;
		if (t > ntc_pkg::T_MAX) begin
			fault = 1'b1;
			return ntc_pkg::T_MAX;
		end
		if (t < ntc_pkg::T_MIN) begin
			fault = 1'b1;
			return ntc_pkg::T_MIN;
		end
		return int'(t);
	endfunction

	function automatic void accumulate(logic [2:0] ch, logic [11:0] smp);
		logic [8:0] n;
		longint unsigned c;
		reading_t r;
		n = (m_avg == 0) ? 9'd1 : {1'b0, m_avg};
		if (grp_cnt == 0 || ch != grp_ch) begin
			grp_sum = '0;
			grp_cnt = '0;
			grp_ch = ch;
		end
		grp_sum = grp_sum + 20'(smp);
		grp_cnt = grp_cnt + 8'd1;
		if (grp_cnt != 0 && {1'b0, grp_cnt} < n)
			return;
		c = (grp_cnt == 0) ? 256 : grp_cnt;
		r.ch = grp_ch;
		r.fault = 1'b0;
		r.open = 1'b0;
		if (64'(grp_sum) < 64'(m_thr) * c) begin
			r.open = 1'b1;
			r.temp = 18'(ntc_pkg::T_MIN);
		end else begin
			r.temp = 18'(beta_temp(grp_ch, grp_sum, c, r.fault));
		end
		readings_due.push_back(r);
		grp_sum = '0;
		grp_cnt = '0;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what,
			$signed(got), $signed(want));
		errors++;
	endtask

	// Sender: one sample transaction at a time from the pending list.
	always @(posedge clk) begin
		if (push && !full) begin
			accumulate(probe_channel, adc_sample);
			n_samples++;
		end
		if (arst_n && (!push || !full)) begin
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (samples_to_send.size() > 0) begin
				probe_channel <= samples_to_send[0].ch;
				adc_sample <= samples_to_send[0].smp;
				void'(samples_to_send.pop_front());
				push <= 1'b1;
				send_gap = idle_len();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: checks each popped temperature transaction.
	always @(posedge clk) begin
		reading_t e;
		if (pop && !empty) begin
			if (readings_due.size() == 0) begin
				report("unexpected result, channel", 32'(out_channel), 0);
			end else begin
				e = readings_due.pop_front();
				n_readings++;
				if (e.open)
					n_open++;
				if (e.fault)
					n_fault++;
				if (temp_out !== e.temp)
					report("temp_out", 32'(temp_out), 32'(e.temp));
				if (out_channel !== e.ch)
					report("out_channel", 32'(out_channel), 32'(e.ch));
				if (open_circuit !== e.open)
					report("open_circuit", 32'(open_circuit), 32'(e.open));
				if (range_fault !== e.fault)
					report("range_fault", 32'(range_fault), 32'(e.fault));
			end
		end
		if (arst_n) begin
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1;
				hold_left = 1500;
				pop <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				recv_gap = idle_len();
			end
		end
	end

	task automatic write_reg(ntc_pkg::cfg_idx_t idx, logic [12:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			ntc_pkg::CFG_AVG_COUNT:  m_avg = val[7:0];
			ntc_pkg::CFG_OPEN_THR:   m_thr = val[11:0];
			ntc_pkg::CFG_BETA_CABLE: m_beta_cable = val;
			ntc_pkg::CFG_BETA_SMD:   m_beta_smd = val;
			ntc_pkg::CFG_BETA_FIX:   m_beta_fix = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Waits until the block has drained, plus its worst conversion time.
	task automatic wait_idle();
		while (samples_to_send.size() != 0 || push || readings_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic add(logic [2:0] ch, logic [11:0] smp);
		sample_t s;
		s.ch = ch;
		s.smp = smp;
		samples_to_send.push_back(s);
	endtask

	// Mostly whole groups of one channel around a drifting level, some broken ones.
	task automatic add_random(int count, int grp);
		int k, len, base, r;
		logic [2:0] ch;
		k = 0;
		while (k < count) begin
			ch = 3'($urandom_range(0, 7));
			r = $urandom_range(0, 9);
			base = (r < 2) ? $urandom_range(0, 60) : (r < 3) ? $urandom_range(4000, 4095) :
				$urandom_range(0, 4095);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, grp) : grp;
			for (int j = 0; j < len; j++) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					add(ch, 12'($urandom_range(0, 4095)));
				else if (r == 1)
					add(3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
				else
					add(ch, 12'(base + $urandom_range(0, 16) - 8));
				k++;
			end
		end
	endtask

	initial begin
		fill_log2_tab();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: field extremes, every channel, around the open threshold.
		add(3'd0, 12'd0);
		add(3'd1, 12'd26);
		add(3'd2, 12'd27);
		add(3'd3, 12'd4095);
		add(3'd4, 12'd4094);
		add(3'd5, 12'd2048);
		add(3'd6, 12'd1365);
		add(3'd7, 12'd2730);
		add(3'd6, 12'd4095);
		add(3'd7, 12'd100);
		add(3'd5, 12'd3500);
		wait_idle();

		write_reg(ntc_pkg::CFG_AVG_COUNT, 13'd3);
		write_reg(ntc_pkg::CFG_OPEN_THR, 13'd0);
		write_reg(ntc_pkg::CFG_BETA_CABLE, 13'd1000);
		write_reg(ntc_pkg::CFG_BETA_SMD, 13'd8191);
		write_reg(ntc_pkg::CFG_BETA_FIX, 13'd8000);
		// A channel change discards the partial group.
		add(3'd1, 12'd500);
		add(3'd1, 12'd600);
		add(3'd2, 12'd700);
		add(3'd2, 12'd800);
		add(3'd2, 12'd900);
		add(3'd0, 12'd0);
		add(3'd0, 12'd0);
		add(3'd0, 12'd0);
		add(3'd6, 12'd4095);
		add(3'd6, 12'd4095);
		add(3'd6, 12'd4095);
		add_random(300, 3);
		wait_idle();

		// Lowering the group size below the running count closes the group.
		write_reg(ntc_pkg::CFG_AVG_COUNT, 13'd8);
		for (int i = 0; i < 5; i++)
			add(3'd3, 12'd1800);
		wait_idle();
		write_reg(ntc_pkg::CFG_AVG_COUNT, 13'd2);
		add(3'd3, 12'd1900);
		add_random(200, 2);
		wait_idle();

		// Group size zero acts as one; zero beta; highest threshold; input backs up.
		write_reg(ntc_pkg::CFG_AVG_COUNT, 13'd0);
		write_reg(ntc_pkg::CFG_BETA_CABLE, 13'd0);
		write_reg(ntc_pkg::CFG_BETA_SMD, 13'd0);
		write_reg(ntc_pkg::CFG_BETA_FIX, 13'd0);
		write_reg(ntc_pkg::CFG_OPEN_THR, 13'd4095);
		add(3'd0, 12'd4095);
		add(3'd7, 12'd4094);
		wait_idle();
		write_reg(ntc_pkg::CFG_OPEN_THR, 13'd10);
		no_idle = 1;
		long_hold_req = 1;
		add_random(200, 1);
		wait_idle();
		no_idle = 0;

		write_reg(ntc_pkg::CFG_AVG_COUNT, 13'd255);
		write_reg(ntc_pkg::CFG_OPEN_THR, 13'd2000);
		write_reg(ntc_pkg::CFG_BETA_CABLE, 13'd3977);
		write_reg(ntc_pkg::CFG_BETA_FIX, 13'd5000);
		for (int i = 0; i < 255; i++)
			add(3'd4, 12'd4095);
		for (int i = 0; i < 255; i++)
			add(3'd7, 12'($urandom_range(1500, 2600)));
		wait_idle();

		for (int p = 0; p < 4; p++) begin
			write_reg(ntc_pkg::CFG_AVG_COUNT, 13'($urandom_range(1, 6)));
			write_reg(ntc_pkg::CFG_OPEN_THR, 13'($urandom_range(0, 200)));
			write_reg(ntc_pkg::CFG_BETA_CABLE, 13'($urandom_range(1000, 8191)));
			write_reg(ntc_pkg::CFG_BETA_SMD, 13'($urandom_range(1000, 8191)));
			write_reg(ntc_pkg::CFG_BETA_FIX, 13'($urandom_range(1000, 8191)));
			no_idle = (p == 2);
			add_random(200, int'(m_avg));
			wait_idle();
		end

		$display("Covered %0d samples and %0d temperature results (%0d open, %0d range faults)",
			n_samples, n_readings, n_open, n_fault);
		$display("over group sizes 0 to 255, thresholds 0 to 4095 and beta 0 to 8191.");
		if (errors == 0)
			$display("ntc_thermistor_temperature_top test passed");
		else
			$display("ntc_thermistor_temperature_top test failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Timeout with %0d results still expected", readings_due.size());
		$display("ntc_thermistor_temperature_top test failed");
		$finish;
	end

endmodule
